// ----- design/bpfa_pkg.sv -----
// shared types, codes and helper functions for the page frame allocator
package bpfa_pkg;

	// word field types
	typedef logic [1:0]  opcode_t;
	typedef logic [14:0] page_t;
	typedef logic [1:0]  status_t;
	typedef logic [15:0] count_t;
	typedef logic [1:0]  cfg_idx_t;
	typedef logic [15:0] cfg_data_t;

	// opcodes
	localparam opcode_t OP_INIT  = 2'd0;
	localparam opcode_t OP_ALLOC = 2'd1;
	localparam opcode_t OP_FREE  = 2'd2;
	localparam opcode_t OP_NOP   = 2'd3;

	// result status codes
	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_OOM = 2'd1;
	localparam status_t ST_IGN = 2'd2;

	// register indexes
	localparam cfg_idx_t CFG_TOTAL    = 2'd0;
	localparam cfg_idx_t CFG_RESERVED = 2'd1;

	// register reset values
	localparam cfg_data_t TOTAL_RST    = 16'd32768;
	localparam cfg_data_t RESERVED_RST = 16'd256;

	// bits per bitmap word
	localparam int WORD_BITS = 32;

	// controller to datapath commands
	typedef struct packed {
		logic    addr_clr;
		logic    fill_ones;
		logic    fill_init;
		logic    init_cnt;
		logic    scan;
		logic    alloc_wr;
		logic    rd_page;
		logic    clr_page;
		logic    capture;
		logic    res_load;
		status_t res_status;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last_word;
		logic found;
		logic scan_end;
		logic page_ok;
		logic bit_used;
	} dp_stat_t;

	// mask with the lowest n bits set, n up to 32
	function automatic logic [31:0] below_mask(input logic [5:0] n);
		logic [31:0] m;
		if (n[5]) begin
			m = '1;
		end else begin
			m = (32'd1 << n[4:0]) - 32'd1;
		end
		return m;
	endfunction

	// index of the lowest set bit
	function automatic logic [4:0] lowest_set(input logic [31:0] v);
		logic [4:0] idx;
		idx = '0;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- design/bpfa_if.sv -----
// valid/ready channel interfaces for requests, results and register writes
interface bpfa_req_if;
	import bpfa_pkg::*;
	logic    valid;
	logic    ready;
	opcode_t opcode;
	page_t   page_number;
	modport source (output valid, opcode, page_number, input ready);
	modport sink (input valid, opcode, page_number, output ready);
endinterface

interface bpfa_rsp_if;
	import bpfa_pkg::*;
	logic    valid;
	logic    ready;
	status_t status;
	page_t   allocated_page;
	count_t  free_count;
	modport source (output valid, status, allocated_page, free_count, input ready);
	modport sink (input valid, status, allocated_page, free_count, output ready);
endinterface

interface bpfa_cfg_if;
	import bpfa_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/bpfa_dp.sv -----
// datapath: bitmap memory, counters, config registers and result registers
module bpfa_dp #(
	parameter int MAX_PAGES = 32768
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bpfa_pkg::dp_cmd_t   cmd,
	output bpfa_pkg::dp_stat_t  stat,
	input  logic                cfg_we,
	input  bpfa_pkg::cfg_idx_t  cfg_index,
	input  bpfa_pkg::cfg_data_t cfg_data,
	input  bpfa_pkg::page_t     page_number,
	output bpfa_pkg::status_t   status,
	output bpfa_pkg::page_t     allocated_page,
	output bpfa_pkg::count_t    free_count
);
	import bpfa_pkg::*;

	localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = $clog2(WORDS);
	localparam int PW    = AW + 5;
	localparam int TW    = $clog2(MAX_PAGES + 1);
	localparam int CW    = (TW > 16) ? TW : 16;
	localparam int EW    = CW + 1;

	// offset of a limit into the word at base, clamped to 0..32
	function automatic logic [5:0] word_cut(input logic [EW-1:0] lim, input logic [EW-1:0] base);
		logic [EW-1:0] d;
		logic [5:0]    r;
		d = lim - base;
		if (lim <= base) begin
			r = 6'd0;
		end else if (d >= EW'(WORD_BITS)) begin
			r = 6'd32;
		end else begin
			r = d[5:0];
		end
		return r;
	endfunction

	logic [31:0]   mem [WORDS];
	logic [31:0]   rdata_s1;
	logic          rvalid_s1;
	logic [AW-1:0] raddr_s1;
	logic [AW:0]   addr_q;
	logic [15:0]   total_q;
	logic [15:0]   reserved_q;
	logic [TW-1:0] used_q;
	page_t         pg_q;
	logic [PW-1:0] page_q;
	logic          give_q;
	status_t       status_q;
	page_t         alloc_q;
	count_t        free_q;

	logic [TW-1:0] tot;
	logic [TW:0]   tot_round;
	logic [AW:0]   nwords;
	logic          issue;
	logic [CW-1:0] pg_e;
	logic [AW-1:0] pg_word;
	logic [4:0]    pg_bit;
	logic [31:0]   init_word;
	logic [31:0]   free_bits;
	logic [4:0]    free_idx;
	logic [PW-1:0] found_page;
	logic          we;
	logic [AW-1:0] wa;
	logic [31:0]   wd;
	logic          re;
	logic [AW-1:0] ra;
	logic [CW-1:0] free_e;

	// effective total and number of words to search
	assign tot       = (CW'(total_q) < CW'(MAX_PAGES)) ? TW'(total_q) : TW'(MAX_PAGES);
	assign tot_round = {1'b0, tot} + (TW + 1)'(WORD_BITS - 1);
	assign nwords    = (AW + 1)'(tot_round >> 5);
	assign issue     = addr_q < nwords;

	// requested page split into word and bit
	assign pg_e    = CW'(pg_q);
	assign pg_word = pg_e[PW-1:5];
	assign pg_bit  = pg_e[4:0];

	// init pattern: used below reserved and at or above total
	assign init_word = below_mask(word_cut(EW'(reserved_q), EW'({addr_q[AW-1:0], 5'b0})))
		| ~below_mask(word_cut(EW'(tot), EW'({addr_q[AW-1:0], 5'b0})));

	// free frames in the word under test, limited to the total
	assign free_bits  = ~rdata_s1 & below_mask(word_cut(EW'(tot), EW'({raddr_s1, 5'b0})));
	assign free_idx   = lowest_set(free_bits);
	assign found_page = {raddr_s1, free_idx};

	// status back to the controller
	assign stat.last_word = addr_q == (AW + 1)'(WORDS - 1);
	assign stat.found     = rvalid_s1 && (free_bits != '0);
	assign stat.scan_end  = !rvalid_s1 && !issue;
	assign stat.page_ok   = CW'(pg_q) < CW'(tot);
	assign stat.bit_used  = rdata_s1[pg_bit];

	// memory port selection
	always_comb begin
		we = 1'b0;
		wa = addr_q[AW-1:0];
		wd = '1;
		priority if (cmd.fill_ones) begin
			we = 1'b1;
		end else if (cmd.fill_init) begin
			we = 1'b1;
			wd = init_word;
		end else if (cmd.alloc_wr) begin
			we = 1'b1;
			wa = raddr_s1;
			wd = rdata_s1 | (32'd1 << free_idx);
		end else if (cmd.clr_page) begin
			we = 1'b1;
			wa = pg_word;
			wd = rdata_s1 & ~(32'd1 << pg_bit);
		end
		re = (cmd.scan && issue) || cmd.rd_page;
		ra = cmd.rd_page ? pg_word : addr_q[AW-1:0];
	end

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_s1 <= mem[ra];
		end
	end

	// word counter and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.scan && issue;
			if (cmd.addr_clr) begin
				addr_q <= '0;
			end else if (cmd.fill_ones || cmd.fill_init || (cmd.scan && issue)) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// address of the word in flight
	always_ff @(posedge clk) begin
		raddr_s1 <= addr_q[AW-1:0];
	end

	// config registers and used count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RST;
			reserved_q <= RESERVED_RST;
			used_q     <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_TOTAL) begin
				total_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_RESERVED) begin
				reserved_q <= cfg_data;
			end
			priority if (cmd.init_cnt) begin
				used_q <= (EW'(reserved_q) < EW'(tot)) ? TW'(reserved_q) : tot;
			end else if (cmd.alloc_wr) begin
				if (used_q < TW'(MAX_PAGES)) begin
					used_q <= used_q + 1'b1;
				end
			end else if (cmd.clr_page) begin
				if (used_q != '0) begin
					used_q <= used_q - 1'b1;
				end
			end
		end
	end

	// request page and allocated frame
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pg_q   <= page_number;
			give_q <= 1'b0;
		end
		if (cmd.alloc_wr) begin
			page_q <= found_page;
			give_q <= 1'b1;
		end
	end

	// result word registers
	assign free_e = (tot > used_q) ? CW'(tot - used_q) : '0;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			alloc_q  <= give_q ? page_t'(CW'(page_q)) : '0;
			free_q   <= free_e[15:0];
		end
	end

	assign status         = status_q;
	assign allocated_page = alloc_q;
	assign free_count     = free_q;

	// used count never passes the store size
	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(used_q) <= CW'(MAX_PAGES))
		else $error("used count above store size");

	// a found frame lies below the total
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.found |-> (CW'(found_page) < CW'(tot)))
		else $error("found frame outside managed range");

	// only a used frame gets released
	a_clr_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_page |-> stat.bit_used)
		else $error("release of a free frame");

endmodule

// ----- design/bpfa_ctrl.sv -----
// controller: sequences clear, init, search and release over the datapath
module bpfa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  bpfa_pkg::opcode_t   opcode,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bpfa_pkg::dp_cmd_t   cmd,
	input  bpfa_pkg::dp_stat_t  stat
);
	import bpfa_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_INIT  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_FCHK  = 3'd4;
	localparam logic [2:0] S_FWR   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;
	localparam logic [2:0] S_SPARE = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	status_t    st_q;
	status_t    st_d;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		st_d    = st_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.fill_ones = 1'b1;
				if (stat.last_word) begin
					cmd.addr_clr = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					unique case (opcode)
						OP_INIT: begin
							cmd.addr_clr = 1'b1;
							cmd.init_cnt = 1'b1;
							state_d      = S_INIT;
						end
						OP_ALLOC: begin
							cmd.addr_clr = 1'b1;
							state_d      = S_SCAN;
						end
						OP_FREE: begin
							state_d = S_FCHK;
						end
						OP_NOP: begin
							st_d    = ST_IGN;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_INIT: begin
				cmd.fill_init = 1'b1;
				if (stat.last_word) begin
					st_d    = ST_OK;
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				priority if (stat.found) begin
					cmd.alloc_wr = 1'b1;
					st_d         = ST_OK;
					state_d      = S_DONE;
				end else if (stat.scan_end) begin
					st_d    = ST_OOM;
					state_d = S_DONE;
				end
			end
			S_FCHK: begin
				if (stat.page_ok) begin
					cmd.rd_page = 1'b1;
					state_d     = S_FWR;
				end else begin
					st_d    = ST_IGN;
					state_d = S_DONE;
				end
			end
			S_FWR: begin
				if (stat.bit_used) begin
					cmd.clr_page = 1'b1;
					st_d         = ST_OK;
				end else begin
					st_d = ST_IGN;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.res_status = st_q;
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SPARE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, pending status and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// an accepted word always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted word left in idle");

	// a result appears only out of the done state
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside done");

	// a hit ends the search at once
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && stat.found) |=> state_q == S_DONE)
		else $error("search continued past a hit");

endmodule

// ----- design/bitmap_page_frame_allocator_top.sv -----
// Bitmap page frame allocator, first fit: one used bit per frame in a 32-bit word memory.
// Alloc: the search reads one bitmap word per cycle, first fit up to the total.
// Init: one word written per cycle over the whole store; free reads the frame's word, then clears its bit.
// One word in work at a time; the next is taken while a result waits in the output register.
// After reset a clearing pass over every bitmap word sets every frame used; no word is
// taken until it ends, register writes are taken at all times.
module bitmap_page_frame_allocator_top #(
	parameter int MAX_PAGES = 32768
) (
	input  logic       clk,
	input  logic       arst_n,
	bpfa_req_if.sink   req,
	bpfa_rsp_if.source rsp,
	bpfa_cfg_if.sink   cfg
);
	import bpfa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     cfg_we;

	// register writes always accepted
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;

	// sequencer
	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.opcode    (req.opcode),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// bitmap and counters
	bpfa_dp #(
		.MAX_PAGES (MAX_PAGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.page_number    (req.page_number),
		.status         (rsp.status),
		.allocated_page (rsp.allocated_page),
		.free_count     (rsp.free_count)
	);

endmodule

// ----- test/bitmap_page_frame_allocator_top_test.sv -----
// self-checking testbench for the bitmap page frame allocator: directed and random words
`timescale 1ns / 100ps

module bitmap_page_frame_allocator_top_test;
	import bpfa_pkg::*;

	localparam int          FRAMES         = 32768;
	localparam int          HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int          TAIL_CYCLES    = 1100;

	typedef struct {
		status_t status;
		page_t   page;
		count_t  free_cnt;
	} alloc_result_t;

	// mirror of the allocator state and the outcomes it predicts
	class frame_alloc_scoreboard;
		bit [31:0]     used_map [FRAMES/32];
		int unsigned   used_cnt;
		cfg_data_t     total_reg;
		cfg_data_t     reserved_reg;
		alloc_result_t pending_results [$];
		page_t         given_pages [$];
		int            errors;
		int            n_checked;
		int            n_given;
		int            n_oom;
		int            n_freed;
		int            n_ignored;
		int            n_inits;

		function new();
			foreach (used_map[w]) used_map[w] = '1;
			used_cnt     = 0;
			total_reg    = TOTAL_RST;
			reserved_reg = RESERVED_RST;
			errors       = 0;
			n_checked    = 0;
			n_given      = 0;
			n_oom        = 0;
			n_freed      = 0;
			n_ignored    = 0;
			n_inits      = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_data_t val);
			case (idx)
				CFG_TOTAL:    total_reg = val;
				CFG_RESERVED: reserved_reg = val;
				default: ;
			endcase
		endfunction

		// frames actually managed, clamped to the store size
		function int unsigned usable_frames();
			return (total_reg < FRAMES) ? int'(total_reg) : FRAMES;
		endfunction

		// work out the result of one accepted request and queue it
		function void take_request(opcode_t op, page_t pg);
			alloc_result_t r;
			int unsigned   tot;
			bit [31:0]     avail;
			bit            hit;
			tot      = usable_frames();
			r.status = ST_OK;
			r.page   = '0;
			hit      = 1'b0;
			case (op)
				OP_INIT: begin
					for (int i = 0; i < FRAMES; i++) begin
						used_map[i / 32][i % 32] = (i < reserved_reg) || (i >= tot);
					end
					used_cnt = (reserved_reg < tot) ? int'(reserved_reg) : tot;
					given_pages.delete();
					n_inits++;
				end
				OP_ALLOC: begin
					r.status = ST_OOM;
					// first fit, skipping full words
					for (int w = 0; (w * 32 < tot) && !hit; w++) begin
						avail = ~used_map[w];
						if (avail != 0) begin
							for (int b = 0; (b < 32) && !hit; b++) begin
								if (avail[b] && (w * 32 + b < tot)) begin
									hit            = 1'b1;
									used_map[w][b] = 1'b1;
									if (used_cnt < FRAMES) used_cnt++;
									r.status = ST_OK;
									r.page   = page_t'(w * 32 + b);
								end
							end
						end
					end
					if (hit) begin
						given_pages.push_back(r.page);
						n_given++;
					end else begin
						n_oom++;
					end
				end
				OP_FREE: begin
					if ((pg < tot) && used_map[pg[14:5]][pg[4:0]]) begin
						used_map[pg[14:5]][pg[4:0]] = 1'b0;
						if (used_cnt > 0) used_cnt--;
						n_freed++;
					end else begin
						r.status = ST_IGN;
						n_ignored++;
					end
				end
				default: begin
					r.status = ST_IGN;
					n_ignored++;
				end
			endcase
			r.free_cnt = count_t'((tot > used_cnt) ? tot - used_cnt : 0);
			pending_results.push_back(r);
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(status_t st, page_t pg, count_t fc);
			alloc_result_t e;
			n_checked++;
			if (pending_results.size() == 0) begin
				$error("result with no request waiting: status %0d page %0d free_count %0d",
					st, pg, fc);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				errors++;
			end
			if (pg !== e.page) begin
				$error("allocated_page: expected %0d, actual %0d", e.page, pg);
				errors++;
			end
			if (fc !== e.free_cnt) begin
				$error("free_count: expected %0d, actual %0d", e.free_cnt, fc);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	bit   calm;
	bit   hold_off;

	frame_alloc_scoreboard sb;

	bpfa_req_if req ();
	bpfa_rsp_if rsp ();
	bpfa_cfg_if cfg ();

	bitmap_page_frame_allocator_top #(
		.MAX_PAGES(FRAMES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watch every channel at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				sb.check_result(rsp.status, rsp.allocated_page, rsp.free_count);
			end
			if (req.valid && req.ready) begin
				sb.take_request(req.opcode, req.page_number);
			end
			if (cfg.valid && cfg.ready) begin
				sb.write_reg(cfg.index, cfg.data);
			end
		end
	end

	// end the run if nothing moves for too long
	initial begin : watchdog
		int unsigned dead_cycles;
		dead_cycles = 0;
		@(posedge arst_n);
		while (dead_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready)) begin
				dead_cycles = 0;
			end else begin
				dead_cycles++;
			end
		end
		$display("FAIL");
		$finish;
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin
		forever begin
			if (hold_off) begin
				rsp.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end else if (!quiet && ($urandom_range(0, 4) == 0)) begin
				rsp.ready = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end else begin
				rsp.ready = 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
	end

	// offer one request word and wait until it is taken
	task automatic send_request(opcode_t op, page_t pg);
		if (!quiet && !calm && ($urandom_range(0, 3) == 0)) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req.valid       = 1'b1;
		req.opcode      = op;
		req.page_number = pg;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// one register write word
	task automatic write_register(cfg_idx_t idx, cfg_data_t val);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data  = val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid = 1'b0;
		@(negedge clk);
	endtask

	// stop offering and wait until every predicted result is back
	task automatic drain();
		req.valid = 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// one random request, mostly allocs and frees of handed-out frames
	task automatic random_request(int unsigned tot);
		int unsigned pick;
		int          k;
		page_t       pg;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			send_request(OP_ALLOC, page_t'($urandom()));
		end else if ((pick < 70) && (sb.given_pages.size() > 0)) begin
			k  = $urandom_range(0, sb.given_pages.size() - 1);
			pg = sb.given_pages[k];
			sb.given_pages.delete(k);
			send_request(OP_FREE, pg);
		end else if ((pick < 85) && (tot > 0)) begin
			send_request(OP_FREE, page_t'($urandom_range(0, tot - 1)));
		end else if (pick < 96) begin
			send_request(OP_FREE, page_t'($urandom()));
		end else if (pick < 99) begin
			send_request(OP_NOP, page_t'($urandom()));
		end else begin
			send_request(OP_INIT, page_t'($urandom()));
		end
	endtask

	// stimulus
	initial begin
		int unsigned tot_w;
		int unsigned res_w;
		int unsigned eff;
		sb              = new();
		quiet           = 1'b0;
		calm            = 1'b0;
		hold_off        = 1'b0;
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.opcode      = OP_NOP;
		req.page_number = '0;
		cfg.valid       = 1'b0;
		cfg.index       = CFG_TOTAL;
		cfg.data        = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// before any init: free with a zero count, then reuse of that frame
		send_request(OP_FREE, page_t'(5));
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, page_t'(32767));
		send_request(OP_NOP, '1);
		// reset registers: reserved frames, double free, free of a reserved frame
		send_request(OP_INIT, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, page_t'(256));
		send_request(OP_FREE, page_t'(256));
		send_request(OP_FREE, '0);

		// no managed frames at all
		drain();
		write_register(CFG_TOTAL, '0);
		write_register(CFG_RESERVED, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, '0);
		send_request(OP_INIT, '0);

		// both registers at their top value: everything used
		drain();
		write_register(CFG_TOTAL, '1);
		write_register(CFG_RESERVED, '1);
		send_request(OP_INIT, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, page_t'(32767));
		send_request(OP_ALLOC, '0);

		// a single frame
		drain();
		write_register(CFG_TOTAL, cfg_data_t'(1));
		write_register(CFG_RESERVED, '0);
		send_request(OP_INIT, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, page_t'(1));

		// total shrunk below the used count
		drain();
		write_register(CFG_TOTAL, cfg_data_t'(64));
		send_request(OP_INIT, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
		drain();
		write_register(CFG_TOTAL, cfg_data_t'(2));
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, page_t'(1));
		send_request(OP_FREE, '0);

		// random phases, each with its own register setting
		for (int ph = 0; ph < 14; ph++) begin
			drain();
			quiet = (ph >= 12);
			calm  = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0:       tot_w = 0;
					1:       tot_w = 1;
					2:       tot_w = FRAMES;
					default: tot_w = $urandom_range(FRAMES + 1, 65535);
				endcase
				res_w = $urandom_range(0, 1500);
			end else begin
				tot_w = $urandom_range(1, 700);
				res_w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, tot_w + 64);
			end
			write_register(CFG_TOTAL, cfg_data_t'(tot_w));
			write_register(CFG_RESERVED, cfg_data_t'(res_w));
			eff = (tot_w < FRAMES) ? tot_w : FRAMES;
			// sometimes keep the old bitmap under the new total
			if ($urandom_range(0, 4) != 0) send_request(OP_INIT, page_t'($urandom()));
			if ((ph == 3) || (ph == 8)) hold_off = 1'b1;
			repeat (40) random_request(eff);
		end

		// let everything come back, then allow for the slowest operation
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("checked %0d results: %0d frames handed out, %0d out of memory, %0d freed",
			sb.n_checked, sb.n_given, sb.n_oom, sb.n_freed);
		$display("  %0d requests ignored, %0d bitmap inits, register extremes and shrinks",
			sb.n_ignored, sb.n_inits);
		if ((sb.errors == 0) && (sb.pending_results.size() == 0)) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
